// ===== src/tirr_pkg.sv =====
package tirr_pkg;

    localparam int FRAME_W  = 32;
    localparam int BUTTON_W = 8;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_BUTTON     = 3'd1,
        OP_START_REC  = 3'd2,
        OP_STOP_REC   = 3'd3,
        OP_START_PLAY = 3'd4,
        OP_STOP_PLAY  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_LAST
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0]  rel;
        logic [BUTTON_W-1:0] button;
        logic                p2;
        logic                down;
    } t_entry;

    typedef struct packed {
        logic  take_rec_origin;
        logic  clear_rec_origin;
        logic  take_play_origin;
        logic  load_rel;
        logic  clear_n;
        logic  store_event;
        logic  clear_count;
        logic  rewind;
        logic  advance;
        logic  load_err;
        t_kind err_kind;
        logic  emit;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic ptr_lt_count;
        logic due;
        logic n_at_max;
        logic out_free;
    } t_sts;

endpackage

// ===== src/timed_input_record_replay.sv =====
// Records timed button events and replays them on ticks.
// Input channel: i_valid / o_ready with i_operation, i_frame_number, i_button_id,
// i_second_player, i_pressed, i_level_active. A beat is taken on valid && ready.
// Output channel: o_valid / i_ready with o_kind, o_out_button, o_out_pressed,
// o_first_player, o_last; o_last marks the final result of one input beat.
// Sequencing: a non-tick operation is taken in S_IDLE and the block stays ready; a
// result-only operation (empty store on play, full store on record) also passes S_LAST to
// load the output register. A replaying tick steps S_RD, S_CHK for each fired event
// (at most MAX_PER_TICK), then S_LAST to hand off the last one when any fired: each event
// needs one read of the event store and one compare of its registered data.
// Ticks outside playback or with the level inactive leave the block in S_IDLE.
// Reset clears the mode flags, the event count, the play pointer and the origins;
// the store itself needs no clearing since only entries below the count are read.
// A receiver stall holds the output register; the block finishes the pending
// event and then waits, taking no new input beat until the last result is loaded.
module timed_input_record_replay #(
    parameter int DEPTH        = 1024,
    parameter int MAX_PER_TICK = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [2:0]                            i_operation,
    input  logic signed [tirr_pkg::FRAME_W-1:0]   i_frame_number,
    input  logic [tirr_pkg::BUTTON_W-1:0]         i_button_id,
    input  logic                                  i_second_player,
    input  logic                                  i_pressed,
    input  logic                                  i_level_active,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_kind,
    output logic [tirr_pkg::BUTTON_W-1:0]         o_out_button,
    output logic                                  o_out_pressed,
    output logic                                  o_first_player,
    output logic                                  o_last
);

    tirr_pkg::t_cmd cmd;
    tirr_pkg::t_sts sts;

    tirr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_level_active (i_level_active),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    tirr_dp #(
        .DEPTH        (DEPTH),
        .MAX_PER_TICK (MAX_PER_TICK)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_frame_number  (i_frame_number),
        .i_button_id     (i_button_id),
        .i_second_player (i_second_player),
        .i_pressed       (i_pressed),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_button    (o_out_button),
        .o_out_pressed   (o_out_pressed),
        .o_first_player  (o_first_player),
        .o_last          (o_last)
    );

endmodule

// ===== src/tirr_ctrl.sv =====
module tirr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_operation,
    input  logic             i_level_active,
    input  tirr_pkg::t_sts   i_sts,
    output tirr_pkg::t_cmd   o_cmd
);

    tirr_pkg::t_state r_state, n_state;
    logic r_rec, n_rec;
    logic r_play, n_play;
    logic r_rov, n_rov;
    logic r_pov, n_pov;
    logic r_pend, n_pend;
    logic fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tirr_pkg::S_IDLE;
            r_rec   <= 1'b0;
            r_play  <= 1'b0;
            r_rov   <= 1'b0;
            r_pov   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rec   <= n_rec;
            r_play  <= n_play;
            r_rov   <= n_rov;
            r_pov   <= n_pov;
            r_pend  <= n_pend;
        end
    end

    assign fire = i_sts.ptr_lt_count && !i_sts.n_at_max && i_sts.due;

    always_comb begin
        n_state = r_state;
        n_rec   = r_rec;
        n_play  = r_play;
        n_rov   = r_rov;
        n_pov   = r_pov;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            tirr_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (tirr_pkg::t_op'(i_operation))
                        tirr_pkg::OP_TICK: begin
                            if (r_rec && !r_rov) begin
                                o_cmd.take_rec_origin = 1'b1;
                                n_rov = 1'b1;
                            end
                            if (r_play && i_level_active) begin
                                o_cmd.load_rel = 1'b1;
                                o_cmd.clear_n  = 1'b1;
                                if (!r_pov) begin
                                    o_cmd.take_play_origin = 1'b1;
                                    n_pov = 1'b1;
                                end
                                n_state = tirr_pkg::S_RD;
                            end
                        end
                        tirr_pkg::OP_BUTTON: begin
                            if (r_rec) begin
                                if (i_sts.count_full) begin
                                    o_cmd.load_err = 1'b1;
                                    o_cmd.err_kind = tirr_pkg::KIND_FULL;
                                    n_pend  = 1'b1;
                                    n_state = tirr_pkg::S_LAST;
                                end else begin
                                    o_cmd.store_event = 1'b1;
                                end
                            end
                        end
                        tirr_pkg::OP_START_REC: begin
                            o_cmd.clear_count      = 1'b1;
                            o_cmd.clear_rec_origin = 1'b1;
                            n_rec  = 1'b1;
                            n_play = 1'b0;
                            n_rov  = 1'b0;
                        end
                        tirr_pkg::OP_STOP_REC: begin
                            n_rec = 1'b0;
                        end
                        tirr_pkg::OP_START_PLAY: begin
                            if (i_sts.count_zero) begin
                                o_cmd.load_err = 1'b1;
                                o_cmd.err_kind = tirr_pkg::KIND_EMPTY;
                                n_pend  = 1'b1;
                                n_state = tirr_pkg::S_LAST;
                            end else begin
                                o_cmd.rewind = 1'b1;
                                n_play = 1'b1;
                                n_rec  = 1'b0;
                                n_pov  = 1'b0;
                            end
                        end
                        tirr_pkg::OP_STOP_PLAY: begin
                            n_play = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            tirr_pkg::S_RD: begin
                n_state = tirr_pkg::S_CHK;
            end
            tirr_pkg::S_CHK: begin
                if (fire) begin
                    // hold while the previous event still waits for the output slot
                    if (!r_pend || i_sts.out_free) begin
                        o_cmd.emit      = r_pend;
                        o_cmd.emit_last = 1'b0;
                        o_cmd.advance   = 1'b1;
                        n_pend  = 1'b1;
                        n_state = tirr_pkg::S_RD;
                    end
                end else begin
                    n_play  = i_sts.ptr_lt_count;
                    n_state = r_pend ? tirr_pkg::S_LAST : tirr_pkg::S_IDLE;
                end
            end
            tirr_pkg::S_LAST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_pend  = 1'b0;
                    n_state = tirr_pkg::S_IDLE;
                end
            end
            default: n_state = tirr_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== src/tirr_dp.sv =====
module tirr_dp #(
    parameter int DEPTH        = 1024,
    parameter int MAX_PER_TICK = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tirr_pkg::t_cmd                    i_cmd,
    output tirr_pkg::t_sts                    o_sts,
    input  logic signed [tirr_pkg::FRAME_W-1:0]  i_frame_number,
    input  logic [tirr_pkg::BUTTON_W-1:0]     i_button_id,
    input  logic                              i_second_player,
    input  logic                              i_pressed,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [tirr_pkg::BUTTON_W-1:0]     o_out_button,
    output logic                              o_out_pressed,
    output logic                              o_first_player,
    output logic                              o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(MAX_PER_TICK + 1);

    tirr_pkg::t_entry mem [DEPTH];
    tirr_pkg::t_entry r_rd;
    tirr_pkg::t_entry wr_entry;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_ptr;
    logic [NW-1:0]               r_n;
    logic [tirr_pkg::FRAME_W-1:0] r_rec_origin;
    logic [tirr_pkg::FRAME_W-1:0] r_play_origin;
    logic [tirr_pkg::FRAME_W-1:0] r_rel;
    logic [tirr_pkg::FRAME_W-1:0] frame_u;

    tirr_pkg::t_kind              r_pkind;
    logic [tirr_pkg::BUTTON_W-1:0] r_pbutton;
    logic                         r_ppressed;
    logic                         r_pfirst;

    logic                         r_ovalid;
    logic                         out_free;

    assign frame_u          = i_frame_number;
    assign wr_entry.rel     = frame_u - r_rec_origin;
    assign wr_entry.button  = i_button_id;
    assign wr_entry.p2      = i_second_player;
    assign wr_entry.down    = i_pressed;

    // event store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_event) begin
            mem[r_count[AW-1:0]] <= wr_entry;
        end
        r_rd <= mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_ptr         <= '0;
            r_rec_origin  <= '0;
            r_play_origin <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.store_event) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.rewind) begin
                r_ptr <= '0;
            end else if (i_cmd.advance) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.clear_rec_origin) begin
                r_rec_origin <= '0;
            end else if (i_cmd.take_rec_origin) begin
                r_rec_origin <= frame_u;
            end
            if (i_cmd.take_play_origin) begin
                r_play_origin <= frame_u;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rel) begin
            r_rel <= i_cmd.take_play_origin ? '0 : frame_u - r_play_origin;
        end
        if (i_cmd.clear_n) begin
            r_n <= '0;
        end else if (i_cmd.advance) begin
            r_n <= r_n + NW'(1);
        end
        if (i_cmd.load_err) begin
            r_pkind    <= i_cmd.err_kind;
            r_pbutton  <= '0;
            r_ppressed <= 1'b0;
            r_pfirst   <= 1'b0;
        end else if (i_cmd.advance) begin
            r_pkind    <= tirr_pkg::KIND_EVENT;
            r_pbutton  <= r_rd.button;
            r_ppressed <= r_rd.down;
            r_pfirst   <= ~r_rd.p2;
        end
        if (i_cmd.emit) begin
            o_kind         <= r_pkind;
            o_out_button   <= r_pbutton;
            o_out_pressed  <= r_ppressed;
            o_first_player <= r_pfirst;
            o_last         <= i_cmd.emit_last;
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;

    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.count_full   = (r_count == CW'(DEPTH));
    assign o_sts.ptr_lt_count = (r_ptr < r_count);
    assign o_sts.due          = ($signed(r_rd.rel) <= $signed(r_rel));
    assign o_sts.n_at_max     = (r_n == NW'(MAX_PER_TICK));
    assign o_sts.out_free     = out_free;

endmodule

// ===== src/tirr_checker.sv =====
module tirr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [2:0]                          i_operation,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [1:0]                          o_kind,
    input logic [tirr_pkg::BUTTON_W-1:0]       o_out_button,
    input logic                                o_out_pressed,
    input logic                                o_first_player,
    input logic                                o_last
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_out_button)
            && $stable(o_out_pressed) && $stable(o_first_player) && $stable(o_last))
        else $error("stalled result changed");

    // error results stand alone with cleared event fields
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != tirr_pkg::KIND_EVENT) |->
            o_last && (o_out_button == '0) && !o_out_pressed && !o_first_player)
        else $error("malformed error result");

    // while a tick still has results to deliver, no new beat is taken
    a_busy_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken in the middle of a burst");

    // mode-only operations return to idle at once
    a_mode_op_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_operation == tirr_pkg::OP_START_REC
            || i_operation == tirr_pkg::OP_STOP_REC
            || i_operation == tirr_pkg::OP_STOP_PLAY) |=> o_ready)
        else $error("mode operation left the block busy");

endmodule

bind timed_input_record_replay tirr_checker u_tirr_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH        = 1024;
    localparam int MAX_PER_TICK = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_BEATS = 180;
    localparam int TAIL_CYCLES  = 40;

    // codes the block must ignore
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] frame;
        logic [7:0]  button;
        logic        p2;
        logic        down;
        logic        level;
        bit          pause;
    } t_beat;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] button;
        logic       pressed;
        logic       p1;
        logic       last;
    } t_replay;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_operation = '0;
    logic [31:0] i_frame_number = '0;
    logic [7:0]  i_button_id = '0;
    logic        i_second_player = 1'b0;
    logic        i_pressed = 1'b0;
    logic        i_level_active = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_button;
    logic        o_out_pressed;
    logic        o_first_player;
    logic        o_last;

    timed_input_record_replay #(
        .DEPTH        (DEPTH),
        .MAX_PER_TICK (MAX_PER_TICK)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_frame_number  (i_frame_number),
        .i_button_id     (i_button_id),
        .i_second_player (i_second_player),
        .i_pressed       (i_pressed),
        .i_level_active  (i_level_active),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_button    (o_out_button),
        .o_out_pressed   (o_out_pressed),
        .o_first_player  (o_first_player),
        .o_last          (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_beat   stim_q[$];
    t_replay results_due[$];
    t_beat   cur_beat;

    int beats_in = 0;
    int results_seen = 0;
    int mismatches = 0;
    int kind_tally[3] = '{0, 0, 0};
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 8;
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    wire hold_off = (hold_left != 0);

    // event log and mode state of the predicted block
    logic [31:0] log_rel [DEPTH];
    logic [7:0]  log_btn [DEPTH];
    logic        log_p2 [DEPTH];
    logic        log_down [DEPTH];
    int unsigned log_count = 0;
    int unsigned replay_ptr = 0;
    logic        rec_on = 1'b0;
    logic        replay_on = 1'b0;
    logic [31:0] rec_origin = '0;
    logic        rec_origin_ok = 1'b0;
    logic [31:0] replay_origin = '0;
    logic        replay_origin_ok = 1'b0;

    task automatic append_result(input t_replay r);
        results_due.insert(results_due.size(), r);
    endtask

    task automatic push_error(input logic [1:0] kind);
        t_replay r;
        r = '{kind, 8'h00, 1'b0, 1'b0, 1'b1};
        append_result(r);
    endtask

    task automatic model_beat(input t_beat b);
        logic signed [31:0] now_rel;
        logic signed [31:0] ev_rel;
        t_replay r;
        int fired;
        fired = 0;
        case (b.op)
            tirr_pkg::OP_TICK: begin
                if (rec_on && !rec_origin_ok) begin
                    rec_origin = b.frame;
                    rec_origin_ok = 1'b1;
                end
                if (replay_on && b.level) begin
                    if (!replay_origin_ok) begin
                        replay_origin = b.frame;
                        replay_origin_ok = 1'b1;
                    end
                    now_rel = b.frame - replay_origin;
                    while (fired < MAX_PER_TICK && replay_ptr < log_count) begin
                        ev_rel = log_rel[replay_ptr];
                        if (ev_rel > now_rel)
                            break;
                        r = '{tirr_pkg::KIND_EVENT, log_btn[replay_ptr],
                              log_down[replay_ptr], ~log_p2[replay_ptr], 1'b0};
                        append_result(r);
                        fired++;
                        replay_ptr++;
                    end
                    if (replay_ptr >= log_count)
                        replay_on = 1'b0;
                    if (fired > 0)
                        results_due[results_due.size() - 1].last = 1'b1;
                end
            end
            tirr_pkg::OP_BUTTON: begin
                if (rec_on) begin
                    if (log_count >= DEPTH) begin
                        push_error(tirr_pkg::KIND_FULL);
                    end else begin
                        log_rel[log_count]  = b.frame - rec_origin;
                        log_btn[log_count]  = b.button;
                        log_p2[log_count]   = b.p2;
                        log_down[log_count] = b.down;
                        log_count++;
                    end
                end
            end
            tirr_pkg::OP_START_REC: begin
                log_count = 0;
                rec_on = 1'b1;
                replay_on = 1'b0;
                rec_origin = '0;
                rec_origin_ok = 1'b0;
            end
            tirr_pkg::OP_STOP_REC: rec_on = 1'b0;
            tirr_pkg::OP_START_PLAY: begin
                if (log_count == 0) begin
                    push_error(tirr_pkg::KIND_EMPTY);
                end else begin
                    replay_ptr = 0;
                    replay_on = 1'b1;
                    rec_on = 1'b0;
                    replay_origin_ok = 1'b0;
                end
            end
            tirr_pkg::OP_STOP_PLAY: replay_on = 1'b0;
            default: ;
        endcase
    endtask

    task automatic queue_beat(input logic [2:0] op, input logic [31:0] frame,
                              input logic [7:0] button, input logic p2, input logic down,
                              input logic level);
        t_beat b;
        b = '{op, frame, button, p2, down, level, 1'b0};
        stim_q.insert(stim_q.size(), b);
    endtask

    // hold the sender until every outstanding result has drained
    task automatic queue_pause();
        t_beat b;
        b = '{tirr_pkg::OP_TICK, 32'h0, 8'h0, 1'b0, 1'b0, 1'b0, 1'b1};
        stim_q.insert(stim_q.size(), b);
    endtask

    task automatic queue_directed();
        queue_beat(tirr_pkg::OP_START_PLAY, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_BUTTON, 32'd7, 8'h11, 1'b1, 1'b1, 1'b1);
        queue_beat(OP_SPARE_6, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        queue_beat(OP_SPARE_7, 32'h0, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_STOP_PLAY, 32'd3, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'd5, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_START_REC, 32'd0, 8'h00, 1'b0, 1'b0, 1'b0);
        // event ahead of the first tick keeps its absolute frame
        queue_beat(tirr_pkg::OP_BUTTON, 32'd100, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_beat(tirr_pkg::OP_TICK, 32'd50, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_BUTTON, 32'd50, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_BUTTON, 32'h8000_0000, 8'h5A, 1'b1, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_BUTTON, 32'h7FFF_FFFF, 8'hA5, 1'b0, 1'b1, 1'b1);
        queue_beat(tirr_pkg::OP_BUTTON, 32'd40, 8'h3C, 1'b1, 1'b1, 1'b0);
        queue_beat(tirr_pkg::OP_STOP_REC, 32'd0, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_BUTTON, 32'd60, 8'h77, 1'b0, 1'b1, 1'b1);
        queue_beat(tirr_pkg::OP_START_PLAY, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'd1000, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_TICK, 32'hFFFF_FFFB, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'd95, 8'h00, 1'b0, 1'b0, 1'b1);
        // relative frame wraps negative: nothing is due
        queue_beat(tirr_pkg::OP_TICK, 32'h7FFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'h7FFF_FFC9, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'h7FFF_FFD0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_START_PLAY, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_STOP_PLAY, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, 32'd200, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_pause();
    endtask

    // record more events than one tick may fire, then drain them at the per-tick cap
    task automatic queue_tick_cap();
        logic [31:0] base;
        base = $urandom;
        queue_beat(tirr_pkg::OP_START_REC, $urandom, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_beat(tirr_pkg::OP_TICK, base, 8'h00, 1'b0, 1'b0, 1'b1);
        repeat (MAX_PER_TICK + 6)
            queue_beat(tirr_pkg::OP_BUTTON, base + $urandom_range(0, 20), 8'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom));
        queue_beat(tirr_pkg::OP_STOP_REC, 32'd0, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_beat(tirr_pkg::OP_START_PLAY, 32'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        base = $urandom;
        queue_beat(tirr_pkg::OP_TICK, base, 8'h00, 1'b0, 1'b0, 1'b1);
        repeat (3)
            queue_beat(tirr_pkg::OP_TICK, base + 32'd50, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_pause();
    endtask

    task automatic queue_random();
        int counted;
        int k;
        logic [31:0] f;
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 3))
                        queue_beat(3'($urandom), $urandom, 8'($urandom), 1'($urandom),
                                   1'($urandom), 1'($urandom));
                end
                2, 3, 4, 5: begin
                    queue_beat(tirr_pkg::OP_START_REC, $urandom, 8'($urandom), 1'($urandom),
                               1'($urandom), 1'($urandom));
                    counted++;
                    if ($urandom_range(0, 3) == 0) begin
                        queue_beat(tirr_pkg::OP_BUTTON, $urandom, 8'($urandom), 1'($urandom),
                                   1'($urandom), 1'($urandom));
                        counted++;
                    end
                    f = $urandom;
                    queue_beat(tirr_pkg::OP_TICK, f, 8'h00, 1'b0, 1'b0, 1'($urandom));
                    counted++;
                    k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                    repeat (k) begin
                        f = f + $urandom_range(0, 6);
                        if ($urandom_range(0, 5) == 0) begin
                            queue_beat(tirr_pkg::OP_TICK, f, 8'h00, 1'b0, 1'b0, 1'($urandom));
                            counted++;
                        end
                        queue_beat(tirr_pkg::OP_BUTTON,
                                   ($urandom_range(0, 15) == 0) ? $urandom : f,
                                   8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                        counted++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        queue_beat(tirr_pkg::OP_STOP_REC, $urandom, 8'h00, 1'b0, 1'b0,
                                   1'($urandom));
                        counted++;
                    end
                end
                default: begin
                    queue_beat(tirr_pkg::OP_START_PLAY, $urandom, 8'h00, 1'b0, 1'b0,
                               1'($urandom));
                    counted++;
                    f = $urandom;
                    repeat ($urandom_range(1, 15)) begin
                        queue_beat(tirr_pkg::OP_TICK, f, 8'($urandom), 1'($urandom),
                                   1'($urandom), ($urandom_range(0, 5) != 0));
                        counted++;
                        f = f + $urandom_range(0, 8);
                        if ($urandom_range(0, 15) == 0) begin
                            queue_beat(($urandom_range(0, 1) == 0) ? tirr_pkg::OP_STOP_PLAY
                                                                   : tirr_pkg::OP_START_REC,
                                       f, 8'h00, 1'b0, 1'b0, 1'b1);
                            counted++;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    // sender: bursts of beats with random gaps, fed from stim_q
    always @(posedge i_clk) begin : drive_proc
        t_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                model_beat(cur_beat);
                beats_in <= beats_in + 1;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (stim_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (stim_q[0].pause) begin
                i_valid <= 1'b0;
                if (results_due.size() == 0)
                    void'(stim_q.pop_front());
            end else begin
                nxt = stim_q.pop_front();
                cur_beat        <= nxt;
                i_operation     <= nxt.op;
                i_frame_number  <= nxt.frame;
                i_button_id     <= nxt.button;
                i_second_player <= nxt.p2;
                i_pressed       <= nxt.down;
                i_level_active  <= nxt.level;
                i_valid         <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // one long receiver hold-off while results are pending
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && o_valid && beats_in >= 60) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // receiver: stall pattern switches between random ready modes
    always @(posedge i_clk) begin : check_proc
        t_replay want;
        int pct;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result arrived with nothing predicted");
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 8'(o_kind), 8'(want.kind));
                    check_field("out_button", o_out_button, want.button);
                    check_field("out_pressed", 8'(o_out_pressed), 8'(want.pressed));
                    check_field("first_player", 8'(o_first_player), 8'(want.p1));
                    check_field("last", 8'(o_last), 8'(want.last));
                    if (want.kind <= tirr_pkg::KIND_FULL)
                        kind_tally[want.kind]++;
                end
                results_seen++;
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: pct = 100;
                1: pct = 75;
                2: pct = 50;
                default: pct = 12;
            endcase
            i_ready <= !hold_off && ($urandom_range(0, 99) < pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        queue_directed();
        queue_tick_cap();
        queue_random();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d input beats, %0d results checked: %0d replayed, %0d empty-store, %0d full",
                 beats_in, results_seen, kind_tally[0], kind_tally[1], kind_tally[2]);
        $display("record and replay with wrapped frames, a burst split over ticks, long stall");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
